[rtl/bitp_pkg.sv]
// shared constants, codes and control types for the bilinear lookup table
// no dependencies; imported by the interfaces and every module but bitp_div
`default_nettype none

package bitp_pkg;

    localparam int DEF_MAX_X_POINTS = 16;
    localparam int DEF_MAX_Y_POINTS = 16;
    localparam int DEF_VALUE_BITS   = 32;

    localparam int VAL_W      = 32;
    localparam int OP_W       = 2;
    localparam int IDX_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // item opcodes
    localparam logic [OP_W-1:0] OP_LOAD_X    = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_Y    = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD_GRID = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY     = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_X_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_COUNT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENABLE = 2'd2;

    // blend pass select
    localparam logic [1:0] BL_ROW0 = 2'd0;
    localparam logic [1:0] BL_ROW1 = 2'd1;
    localparam logic [1:0] BL_COL  = 2'd2;

    typedef struct packed {
        logic       query_start;
        logic       query_off;
        logic       load_wr;
        logic       search_rd;
        logic       pair_load;
        logic       rd_issue;
        logic [1:0] rd_step;
        logic       diff_load;
        logic       div_start;
        logic       mul_load;
        logic       acc_load;
        logic [1:0] blend_sel;
        logic       out_load;
    } bitp_cmd_t;

    typedef struct packed {
        logic search_last;
        logic div_done;
        logic out_free;
    } bitp_status_t;

endpackage

`default_nettype wire

[rtl/bitp_if.sv]
// valid/ready channel interfaces: query/load items, results, configuration writes
// depends on bitp_pkg
`default_nettype none

interface bitp_item_if import bitp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic [IDX_W-1:0]        col_index;
    logic [IDX_W-1:0]        row_index;
    logic signed [VAL_W-1:0] load_value;
    logic signed [VAL_W-1:0] query_x;
    logic signed [VAL_W-1:0] query_y;

    modport source (output valid, opcode, col_index, row_index, load_value, query_x,
                    query_y, input ready);
    modport sink (input valid, opcode, col_index, row_index, load_value, query_x,
                  query_y, output ready);
endinterface

interface bitp_result_if import bitp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] result_value;
    logic                    saturated;

    modport source (output valid, result_value, saturated, input ready);
    modport sink (input valid, result_value, saturated, output ready);
endinterface

interface bitp_cfg_if import bitp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/bitp_div.sv]
// restoring divider for one axis weight: (num << 16) / den, one quotient bit a cycle
// result clamped to [-2^30, 2^30 - 1]; no package dependency
`default_nettype none

module bitp_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [32:0]        num,
    input  wire logic [32:0]        den,
    input  wire logic               neg,
    output logic                    done,
    output logic signed [31:0]      w
);

    localparam logic [30:0] W_POS_MAX = 31'h3FFF_FFFF;
    localparam logic [30:0] W_NEG_MAG = 31'h4000_0000;

    logic        busy_reg, busy_next;
    logic        fix_reg, fix_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [32:0] rem_reg, rem_next;
    logic [30:0] dvd_reg, dvd_next;
    logic [30:0] q_reg, q_next;
    logic [32:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic signed [31:0] w_reg, w_next;

    logic [33:0] trial;
    logic        ge;
    logic [47:0] num_wide;
    logic [47:0] den_wide;

    always_comb
    begin
        num_wide  = {15'b0, num};
        den_wide  = {den, 15'b0};
        trial     = {rem_reg, dvd_reg[30]};
        ge        = trial >= {1'b0, den_reg};

        busy_next = busy_reg;
        fix_next  = 1'b0;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        w_next    = w_reg;

        if (start)
        begin
            done_next = 1'b0;
            den_next  = den;
            neg_next  = neg;
            if (den == 33'd0)
            begin
                w_next    = 32'sd0;
                done_next = 1'b1;
            end
            else if (num_wide >= den_wide)
            begin
                // quotient is at least 2^31, past either clamp
                w_next    = neg ? -$signed({1'b0, W_NEG_MAG}) : $signed({1'b0, W_POS_MAX});
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = {15'b0, num[32:15]};
                dvd_next  = {num[14:0], 16'b0};
                cnt_next  = 5'd0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 33'(trial - {1'b0, den_reg}) : trial[32:0];
            dvd_next = {dvd_reg[29:0], 1'b0};
            q_next   = {q_reg[29:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd30)
            begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end
        else if (fix_reg)
        begin
            if (neg_reg)
                w_next = (q_reg > W_NEG_MAG) ? -$signed({1'b0, W_NEG_MAG})
                                             : -$signed({1'b0, q_reg});
            else
                w_next = (q_reg > W_POS_MAX) ? $signed({1'b0, W_POS_MAX})
                                             : $signed({1'b0, q_reg});
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        w_reg   <= w_next;
    end

    assign done = done_reg;
    assign w    = w_reg;

endmodule

`default_nettype wire

[rtl/bitp_dp.sv]
// datapath: axis and grid memories, breakpoint search, weights, blend unit, result register
// depends on bitp_pkg and bitp_div
`default_nettype none

module bitp_dp import bitp_pkg::*; #(
    parameter int MAX_X_POINTS = DEF_MAX_X_POINTS,
    parameter int MAX_Y_POINTS = DEF_MAX_Y_POINTS,
    parameter int VALUE_BITS   = DEF_VALUE_BITS,
    parameter int NXW          = $clog2(MAX_X_POINTS + 1),
    parameter int NYW          = $clog2(MAX_Y_POINTS + 1)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire bitp_cmd_t               cmd,
    output bitp_status_t                 status,
    input  wire logic [OP_W-1:0]         opcode,
    input  wire logic [IDX_W-1:0]        col_index,
    input  wire logic [IDX_W-1:0]        row_index,
    input  wire logic signed [VAL_W-1:0] load_value,
    input  wire logic signed [VAL_W-1:0] query_x,
    input  wire logic signed [VAL_W-1:0] query_y,
    input  wire logic [NXW-1:0]          nx,
    input  wire logic [NYW-1:0]          ny,
    input  wire logic                    result_ready,
    output logic                         result_valid,
    output logic signed [VAL_W-1:0]      result_value,
    output logic                         saturated
);

    localparam int XW   = $clog2(MAX_X_POINTS);
    localparam int YW   = $clog2(MAX_Y_POINTS);
    localparam int MAXP = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
    localparam int CW   = $clog2(MAXP + 1);
    localparam int GD   = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int GW   = $clog2(GD);
    localparam int EB   = (VALUE_BITS < 16) ? 16 : ((VALUE_BITS > 32) ? 32 : VALUE_BITS);
    localparam logic signed [49:0] VMAX = (50'sd1 <<< (EB - 1)) - 50'sd1;
    localparam logic signed [49:0] VMIN = -VMAX - 50'sd1;
    localparam logic [8:0] MAX_X_9 = 9'(MAX_X_POINTS);
    localparam logic [8:0] MAX_Y_9 = 9'(MAX_Y_POINTS);

    // storage
    logic [VAL_W-1:0] x_mem [MAX_X_POINTS];
    logic [VAL_W-1:0] y_mem [MAX_Y_POINTS];
    logic [VAL_W-1:0] g_mem [GD];

    logic signed [VAL_W-1:0] x_rd_reg, y_rd_reg, g_rd_reg;
    logic [XW-1:0] x_raddr;
    logic [YW-1:0] y_raddr;
    logic [GW-1:0] g_raddr, g_waddr;
    logic x_we, y_we, g_we, col_ok, row_ok;

    // query and search state
    logic signed [VAL_W-1:0] qx_reg, qy_reg;
    logic          zero_reg;
    logic [CW-1:0] srch_cnt_reg, cmp_idx_reg;
    logic          cmp_valid_reg;
    logic          x_found_reg, y_found_reg;
    logic [NXW-1:0] x_ix_reg;
    logic [NYW-1:0] y_ix_reg;

    logic [NXW-1:0] xa, xb;
    logic [NYW-1:0] ya, yb;
    logic [XW-1:0]  x0_reg, x1_reg;
    logic [YW-1:0]  y0_reg, y1_reg;

    logic          rd_valid_reg;
    logic [1:0]    rd_step_reg;
    logic signed [VAL_W-1:0] xa_reg, xb_reg, ya_reg, yb_reg;
    logic signed [VAL_W-1:0] corner_reg [4];

    logic signed [32:0] ex_x_reg, dx_x_reg, ex_y_reg, dx_y_reg;
    logic [32:0] num_x, den_x, num_y, den_y;
    logic        done_x, done_y;
    logic signed [31:0] tx, ty;

    // blend unit
    logic signed [VAL_W-1:0] bl_lo, bl_hi, lo_m_reg;
    logic signed [31:0]      bl_w;
    logic signed [32:0]      bl_diff;
    logic signed [64:0]      prod_reg;
    logic signed [65:0]      acc_sum;
    logic signed [49:0]      acc_r;
    logic                    acc_over;
    logic signed [VAL_W-1:0] acc_val;
    logic signed [VAL_W-1:0] r0_reg, r1_reg, res_reg;
    logic                    sat_reg;

    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] result_value_reg;
    logic                    saturated_reg;

    // loads
    always_comb
    begin
        col_ok  = {5'b0, col_index} < MAX_X_9;
        row_ok  = {5'b0, row_index} < MAX_Y_9;
        x_we    = cmd.load_wr && (opcode == OP_LOAD_X) && col_ok;
        y_we    = cmd.load_wr && (opcode == OP_LOAD_Y) && row_ok;
        g_we    = cmd.load_wr && (opcode == OP_LOAD_GRID) && col_ok && row_ok;
        g_waddr = GW'(GW'(row_index) * GW'(MAX_X_POINTS)) + GW'(col_index);
    end

    // read addresses: search sweep, then breakpoint pair and four corners
    always_comb
    begin
        if (cmd.search_rd)
        begin
            x_raddr = XW'(srch_cnt_reg);
            y_raddr = YW'(srch_cnt_reg);
        end
        else
        begin
            x_raddr = cmd.rd_step[0] ? x1_reg : x0_reg;
            y_raddr = cmd.rd_step[0] ? y1_reg : y0_reg;
        end
        g_raddr = GW'(GW'(cmd.rd_step[1] ? y1_reg : y0_reg) * GW'(MAX_X_POINTS))
                  + GW'(cmd.rd_step[0] ? x1_reg : x0_reg);
    end

    always_ff @(posedge clk)
    begin
        if (x_we)
            x_mem[XW'(col_index)] <= load_value;
        x_rd_reg <= x_mem[x_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (y_we)
            y_mem[YW'(row_index)] <= load_value;
        y_rd_reg <= y_mem[y_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
            g_mem[g_waddr] <= load_value;
        g_rd_reg <= g_mem[g_raddr];
    end

    // neighbour pair from the lower-bound index
    always_comb
    begin
        xa = (x_ix_reg == '0) ? '0 : x_ix_reg - NXW'(1);
        xb = (x_ix_reg > nx - NXW'(1)) ? nx - NXW'(1) : x_ix_reg;
        if (xa == xb)
            xb = (xa + NXW'(1) < nx) ? xa + NXW'(1) : nx - NXW'(1);
        ya = (y_ix_reg == '0) ? '0 : y_ix_reg - NYW'(1);
        yb = (y_ix_reg > ny - NYW'(1)) ? ny - NYW'(1) : y_ix_reg;
        if (ya == yb)
            yb = (ya + NYW'(1) < ny) ? ya + NYW'(1) : ny - NYW'(1);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srch_cnt_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            x_found_reg   <= 1'b0;
            y_found_reg   <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.search_rd;
            rd_valid_reg  <= cmd.rd_issue;
            if (cmd.query_start)
            begin
                srch_cnt_reg <= '0;
                x_found_reg  <= 1'b0;
                y_found_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.search_rd)
                    srch_cnt_reg <= srch_cnt_reg + CW'(1);
                if (cmp_valid_reg && !x_found_reg && (cmp_idx_reg < CW'(nx))
                    && (x_rd_reg >= qx_reg))
                    x_found_reg <= 1'b1;
                if (cmp_valid_reg && !y_found_reg && (cmp_idx_reg < CW'(ny))
                    && (y_rd_reg >= qy_reg))
                    y_found_reg <= 1'b1;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= srch_cnt_reg;
        rd_step_reg <= cmd.rd_step;
        if (cmd.query_start)
        begin
            qx_reg   <= query_x;
            qy_reg   <= query_y;
            zero_reg <= cmd.query_off;
            x_ix_reg <= nx;
            y_ix_reg <= ny;
            sat_reg  <= 1'b0;
        end
        else
        begin
            if (cmp_valid_reg && !x_found_reg && (cmp_idx_reg < CW'(nx))
                && (x_rd_reg >= qx_reg))
                x_ix_reg <= NXW'(cmp_idx_reg);
            if (cmp_valid_reg && !y_found_reg && (cmp_idx_reg < CW'(ny))
                && (y_rd_reg >= qy_reg))
                y_ix_reg <= NYW'(cmp_idx_reg);
            if (cmd.acc_load && acc_over)
                sat_reg <= 1'b1;
        end
        if (cmd.pair_load)
        begin
            x0_reg <= XW'(xa);
            x1_reg <= XW'(xb);
            y0_reg <= YW'(ya);
            y1_reg <= YW'(yb);
        end
        if (rd_valid_reg)
        begin
            corner_reg[rd_step_reg] <= g_rd_reg;
            if (rd_step_reg == 2'd0)
            begin
                xa_reg <= x_rd_reg;
                ya_reg <= y_rd_reg;
            end
            else if (rd_step_reg == 2'd1)
            begin
                xb_reg <= x_rd_reg;
                yb_reg <= y_rd_reg;
            end
        end
        if (cmd.diff_load)
        begin
            ex_x_reg <= {qx_reg[31], qx_reg} - {xa_reg[31], xa_reg};
            dx_x_reg <= {xb_reg[31], xb_reg} - {xa_reg[31], xa_reg};
            ex_y_reg <= {qy_reg[31], qy_reg} - {ya_reg[31], ya_reg};
            dx_y_reg <= {yb_reg[31], yb_reg} - {ya_reg[31], ya_reg};
        end
        if (cmd.mul_load)
        begin
            prod_reg <= bl_w * bl_diff;
            lo_m_reg <= bl_lo;
        end
        if (cmd.acc_load)
        begin
            unique case (cmd.blend_sel)
                BL_ROW0: r0_reg  <= acc_val;
                BL_ROW1: r1_reg  <= acc_val;
                default: res_reg <= acc_val;
            endcase
        end
        if (cmd.out_load)
        begin
            result_value_reg <= zero_reg ? '0 : res_reg;
            saturated_reg    <= zero_reg ? 1'b0 : sat_reg;
        end
    end

    // weights
    always_comb
    begin
        num_x = ex_x_reg[32] ? 33'(-ex_x_reg) : ex_x_reg;
        den_x = dx_x_reg[32] ? 33'(-dx_x_reg) : dx_x_reg;
        num_y = ex_y_reg[32] ? 33'(-ex_y_reg) : ex_y_reg;
        den_y = dx_y_reg[32] ? 33'(-dx_y_reg) : dx_y_reg;
    end

    bitp_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_x),
        .den   (den_x),
        .neg   (ex_x_reg[32] != dx_x_reg[32]),
        .done  (done_x),
        .w     (tx)
    );

    bitp_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_y),
        .den   (den_y),
        .neg   (ex_y_reg[32] != dx_y_reg[32]),
        .done  (done_y),
        .w     (ty)
    );

    // blend: lo + w * (hi - lo), rounded, saturated
    always_comb
    begin
        unique case (cmd.blend_sel)
            BL_ROW0:
            begin
                bl_lo = corner_reg[0];
                bl_hi = corner_reg[1];
                bl_w  = tx;
            end
            BL_ROW1:
            begin
                bl_lo = corner_reg[2];
                bl_hi = corner_reg[3];
                bl_w  = tx;
            end
            default:
            begin
                bl_lo = r0_reg;
                bl_hi = r1_reg;
                bl_w  = ty;
            end
        endcase
        bl_diff  = {bl_hi[31], bl_hi} - {bl_lo[31], bl_lo};
        acc_sum  = $signed({{18{lo_m_reg[31]}}, lo_m_reg, 16'h0000})
                   + $signed({prod_reg[64], prod_reg}) + 66'sd32768;
        acc_r    = acc_sum[65:16];
        acc_over = (acc_r > VMAX) || (acc_r < VMIN);
        if (acc_r > VMAX)
            acc_val = VMAX[31:0];
        else if (acc_r < VMIN)
            acc_val = VMIN[31:0];
        else
            acc_val = acc_r[31:0];
    end

    assign status.search_last = (srch_cnt_reg == CW'(MAXP));
    assign status.div_done    = done_x && done_y;
    assign status.out_free    = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign result_value = result_value_reg;
    assign saturated    = saturated_reg;

endmodule

`default_nettype wire

[rtl/bitp_ctrl.sv]
// controller state machine: writes load items and sequences one query through the datapath
// depends on bitp_pkg
`default_nettype none

module bitp_ctrl import bitp_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         item_valid,
    input  wire logic         item_is_query,
    input  wire logic         table_enable,
    input  wire bitp_status_t status,
    output logic              item_ready,
    output bitp_cmd_t         cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SEARCH = 4'd1;
    localparam logic [3:0] ST_PAIR   = 4'd2;
    localparam logic [3:0] ST_READ   = 4'd3;
    localparam logic [3:0] ST_DIFF   = 4'd4;
    localparam logic [3:0] ST_DIVS   = 4'd5;
    localparam logic [3:0] ST_DIV    = 4'd6;
    localparam logic [3:0] ST_BMUL   = 4'd7;
    localparam logic [3:0] ST_BACC   = 4'd8;
    localparam logic [3:0] ST_FIN    = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] bsel_reg, bsel_next;
    logic       fire;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bsel_next  = bsel_reg;
        cmd        = '0;
        cmd.rd_step   = cnt_reg[1:0];
        cmd.blend_sel = bsel_reg;
        item_ready = (state_reg == ST_IDLE);
        fire       = item_ready && item_valid;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (fire && item_is_query)
                begin
                    cmd.query_start = 1'b1;
                    cmd.query_off   = !table_enable;
                    state_next      = table_enable ? ST_SEARCH : ST_FIN;
                end
                else if (fire)
                    cmd.load_wr = 1'b1;
            end
            ST_SEARCH:
            begin
                cmd.search_rd = !status.search_last;
                if (status.search_last)
                    state_next = ST_PAIR;
            end
            ST_PAIR:
            begin
                cmd.pair_load = 1'b1;
                cnt_next      = 3'd0;
                state_next    = ST_READ;
            end
            ST_READ:
            begin
                // pair reads and four corners, last one latched in the final cycle
                cmd.rd_issue = !cnt_reg[2];
                cnt_next     = cnt_reg + 3'd1;
                if (cnt_reg[2])
                    state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff_load = 1'b1;
                state_next    = ST_DIVS;
            end
            ST_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    bsel_next  = BL_ROW0;
                    state_next = ST_BMUL;
                end
            end
            ST_BMUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_BACC;
            end
            ST_BACC:
            begin
                cmd.acc_load = 1'b1;
                if (bsel_reg == BL_COL)
                    state_next = ST_FIN;
                else
                begin
                    bsel_next  = (bsel_reg == BL_ROW0) ? BL_ROW1 : BL_COL;
                    state_next = ST_BMUL;
                end
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 3'd0;
            bsel_reg  <= BL_ROW0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bsel_reg  <= bsel_next;
        end
    end

endmodule

`default_nettype wire

[rtl/bilinear_interp_table_2d.sv]
// a query's result waits on the serial breakpoint sweep over MAXP = max(MAX_X_POINTS,
//   MAX_Y_POINTS) entries and on the 31-step weight dividers; a disabled query skips
//   both and goes straight to the result register
// throughput: one query at a time, a new item is taken as soon as the previous query is done;
//   a load item every cycle while no query is in progress
// reset: counts to 1, table disabled, no result pending; tables hold garbage until loaded
// depends on bitp_pkg, bitp_if, bitp_div, bitp_dp, bitp_ctrl
`default_nettype none

module bilinear_interp_table_2d import bitp_pkg::*; #(
    parameter int MAX_X_POINTS = DEF_MAX_X_POINTS,
    parameter int MAX_Y_POINTS = DEF_MAX_Y_POINTS,
    parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    bitp_item_if.sink     item,
    bitp_result_if.source result,
    bitp_cfg_if.sink      cfg
);

    localparam int NXW = $clog2(MAX_X_POINTS + 1);
    localparam int NYW = $clog2(MAX_Y_POINTS + 1);
    localparam logic [8:0] MAX_X_9 = 9'(MAX_X_POINTS);
    localparam logic [8:0] MAX_Y_9 = 9'(MAX_Y_POINTS);

    // configuration registers
    logic [CFG_DATA_W-1:0] x_count_reg;
    logic [CFG_DATA_W-1:0] y_count_reg;
    logic                  table_enable_reg;

    // counts in use: zero acts as one, past the table size acts as the size
    logic [8:0]     x_cnt9, y_cnt9;
    logic [NXW-1:0] nx;
    logic [NYW-1:0] ny;

    bitp_cmd_t    cmd;
    bitp_status_t status;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_count_reg      <= 5'd1;
            y_count_reg      <= 5'd1;
            table_enable_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_X_COUNT:      x_count_reg      <= cfg.data;
                CFG_Y_COUNT:      y_count_reg      <= cfg.data;
                CFG_TABLE_ENABLE: table_enable_reg <= cfg.data[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        x_cnt9 = {4'b0, x_count_reg};
        y_cnt9 = {4'b0, y_count_reg};
        if (x_cnt9 == 9'd0)
            x_cnt9 = 9'd1;
        else if (x_cnt9 > MAX_X_9)
            x_cnt9 = MAX_X_9;
        if (y_cnt9 == 9'd0)
            y_cnt9 = 9'd1;
        else if (y_cnt9 > MAX_Y_9)
            y_cnt9 = MAX_Y_9;
        nx = NXW'(x_cnt9);
        ny = NYW'(y_cnt9);
    end

    // sequencer: search, pair and corner reads, weights, three blend passes
    bitp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item.valid),
        .item_is_query (item.opcode == OP_QUERY),
        .table_enable  (table_enable_reg),
        .status        (status),
        .item_ready    (item.ready),
        .cmd           (cmd)
    );

    // memories and arithmetic; the result register decouples the output side
    bitp_dp #(
        .MAX_X_POINTS (MAX_X_POINTS),
        .MAX_Y_POINTS (MAX_Y_POINTS),
        .VALUE_BITS   (VALUE_BITS),
        .NXW          (NXW),
        .NYW          (NYW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .opcode       (item.opcode),
        .col_index    (item.col_index),
        .row_index    (item.row_index),
        .load_value   (item.load_value),
        .query_x      (item.query_x),
        .query_y      (item.query_y),
        .nx           (nx),
        .ny           (ny),
        .result_ready (result.ready),
        .result_valid (result.valid),
        .result_value (result.result_value),
        .saturated    (result.saturated)
    );

endmodule

`default_nettype wire
